FILE: rtl/core/eare_pkg.sv
// ----------------------------------------------------------------------------
// eare_pkg
// Shared types and constants for the echo and reverb effect.
// ----------------------------------------------------------------------------
package eare_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int DELAY_W        = 12;
  localparam int GAIN_W         = 16;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int WIN_W          = 29;
  localparam int PROD_W         = GAIN_W + WIN_W;
  localparam int QUEUE_DEPTH    = 4;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  // register map, byte address 4*index
  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_DELAY = 2'd1,
    REG_GAIN  = 2'd2
  } reg_idx_t;

  typedef enum logic {
    MODE_ECHO   = 1'b0,
    MODE_REVERB = 1'b1
  } effect_mode_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       restart;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } out_word_t;

  typedef struct packed {
    effect_mode_t               effect_mode;
    logic [DELAY_W-1:0]         delay_samples;
    logic signed [GAIN_W-1:0]   decay_gain;
  } cfg_t;

  // classified word handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] delayed;
    logic                       active;
    logic                       restart;
  } task_t;

endpackage

FILE: rtl/core/echo_and_reverb_effect.sv
// ----------------------------------------------------------------------------
// echo_and_reverb_effect
// Echo or box reverb on a 16-bit sample stream, configured over APB.
// ----------------------------------------------------------------------------
// Usage:
//  - sample channel (sample_valid/ready/word) takes one word per sample;
//    restart set marks the first sample of a new stream and clears history.
//  - result channel (result_valid/ready/word) gives exactly one word per
//    sample, in order: the saturated output and a clip flag.
//  - APB port: mode at 0x0, delay at 0x4, gain (Q4.12) at 0x8. Write only
//    while the block is idle; reads return the stored value.
//  - Throughput: one sample per cycle while the result side keeps up, set
//    by one ring write, one ring read and one multiply per sample.
//  - Path: the ring read register, the queue, the multiply register and
//    the round and saturate output register.
//  - A 4-entry queue splits front and back; with the result side stalled,
//    the front keeps taking samples until queue and stages fill (about
//    seven words in flight), then drops sample_ready.
//  - Reset clears pointers, counts and the window sum and loads the register
//    defaults; the ring holds no known data and needs no clearing pass, as
//    entries older than the last restart are never read.
// ----------------------------------------------------------------------------
module echo_and_reverb_effect import eare_pkg::*; #(
  parameter int MAX_DELAY = 4095
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  in_word_t           sample_word,
  output logic               result_valid,
  input  logic               result_ready,
  output out_word_t          result_word
);

  cfg_t     cfg;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic  push_valid;
  logic  push_ready;
  task_t push_word;
  logic  pop_valid;
  logic  pop_ready;
  task_t pop_word;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.effect_mode   <= MODE_ECHO;
      cfg.delay_samples <= DELAY_W'(1);
      cfg.decay_gain    <= GAIN_W'(2048);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MODE:  cfg.effect_mode   <= effect_mode_t'(pwdata[0]);
        REG_DELAY: cfg.delay_samples <= pwdata[DELAY_W-1:0];
        REG_GAIN:  cfg.decay_gain    <= pwdata[GAIN_W-1:0];
        default:   ;  // unmapped address, ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:  prdata = PDATA_W'(cfg.effect_mode);
      REG_DELAY: prdata = PDATA_W'(cfg.delay_samples);
      REG_GAIN:  prdata = PDATA_W'(unsigned'(cfg.decay_gain));
      default:   prdata = '0;
    endcase
  end

  // front: accept, ring access, tap classification
  eare_front #(
    .MAX_DELAY (MAX_DELAY)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (sample_valid),
    .in_ready   (sample_ready),
    .in_word    (sample_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  eare_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  // back: window sum, gain and saturation, result register
  eare_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_word  (pop_word),
    .out_valid (result_valid),
    .out_ready (result_ready),
    .out_word  (result_word)
  );

endmodule

FILE: rtl/core/eare_front.sv
// ----------------------------------------------------------------------------
// eare_front
// Accepts samples, keeps the history ring and tap count, reads the delayed tap.
// ----------------------------------------------------------------------------
module eare_front import eare_pkg::*; #(
  parameter int MAX_DELAY = 4095
) (
  input  logic     clk,
  input  logic     rst,
  input  cfg_t     cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_word,
  output logic     push_valid,
  input  logic     push_ready,
  output task_t    push_word
);

  localparam int EFF_MAX = (MAX_DELAY < 4095) ? MAX_DELAY : 4095;
  localparam int AW      = $clog2(EFF_MAX + 1);
  localparam int DEPTH   = 2 ** AW;

  logic signed [SAMPLE_W-1:0] hist [DEPTH];

  logic [AW-1:0]              wr_pos;
  logic [AW-1:0]              seen;
  logic                       fv;
  logic signed [SAMPLE_W-1:0] rdata;
  logic signed [SAMPLE_W-1:0] x_r;
  logic                       active_r;
  logic                       restart_r;
  logic                       dzero_r;

  logic                       accept;
  logic [DELAY_W-1:0]         d_eff;
  logic [AW-1:0]              seen_eff;
  logic [AW-1:0]              seen_next;
  logic [AW-1:0]              rd_addr;
  logic                       active;

  assign accept   = in_valid && in_ready;
  assign in_ready = !fv || push_ready;

  assign d_eff    = (cfg.delay_samples > DELAY_W'(EFF_MAX)) ? DELAY_W'(EFF_MAX)
                                                            : cfg.delay_samples;
  assign seen_eff = in_word.restart ? '0 : seen;
  assign active   = DELAY_W'(seen_eff) >= d_eff;
  assign rd_addr  = wr_pos - d_eff[AW-1:0];
  assign seen_next = (seen_eff == AW'(EFF_MAX)) ? seen_eff : seen_eff + 1'b1;

  // ring: one write, one registered read per accepted word
  always_ff @(posedge clk) begin
    if (accept) begin
      hist[wr_pos] <= in_word.sample_in;
      rdata        <= hist[rd_addr];
      x_r          <= in_word.sample_in;
      active_r     <= active;
      restart_r    <= in_word.restart;
      dzero_r      <= (d_eff == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv     <= 1'b0;
      wr_pos <= '0;
      seen   <= '0;
    end else begin
      if (accept) begin
        fv     <= 1'b1;
        wr_pos <= wr_pos + 1'b1;
        seen   <= seen_next;
      end else if (push_ready) begin
        fv <= 1'b0;
      end
    end
  end

  assign push_valid        = fv;
  assign push_word.sample  = x_r;
  assign push_word.delayed = dzero_r ? x_r : rdata;   // zero delay taps itself
  assign push_word.active  = active_r;
  assign push_word.restart = restart_r;

endmodule

FILE: rtl/core/eare_queue.sv
// ----------------------------------------------------------------------------
// eare_queue
// Short FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module eare_queue import eare_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  task_t push_word,
  output logic  pop_valid,
  input  logic  pop_ready,
  output task_t pop_word
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  task_t         q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  logic do_push;
  logic do_pop;

  assign push_ready = (count != (PW+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_word   = q[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

FILE: rtl/core/eare_back.sv
// ----------------------------------------------------------------------------
// eare_back
// Window sum, gain multiply, truncation toward zero and saturation.
// ----------------------------------------------------------------------------
module eare_back import eare_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      pop_valid,
  output logic      pop_ready,
  input  task_t     pop_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  localparam logic signed [PROD_W-1:0] Y_MAX = PROD_W'(2 ** (SAMPLE_W - 1) - 1);
  localparam logic signed [PROD_W-1:0] Y_MIN = -Y_MAX - PROD_W'(1);
  localparam logic signed [PROD_W-1:0] BIAS  =
    {{(PROD_W - GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{1'b1}}};

  logic signed [WIN_W-1:0]    wt;
  logic                       s1v;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic signed [PROD_W-1:0]   s1_prod;
  logic                       ov;
  out_word_t                  ow;

  logic                       take;
  logic                       s2_take;
  logic signed [WIN_W-1:0]    wt_base;
  logic signed [WIN_W-1:0]    wt_next;
  logic signed [WIN_W-1:0]    src;
  logic signed [WIN_W-1:0]    x_ext;
  logic signed [WIN_W-1:0]    d_ext;
  logic signed [PROD_W-1:0]   prod_c;
  logic signed [PROD_W-1:0]   biased;
  logic signed [PROD_W-1:0]   term;
  logic signed [PROD_W-1:0]   y;

  assign s2_take   = !ov || out_ready;
  assign pop_ready = !s1v || s2_take;
  assign take      = pop_valid && pop_ready;

  // stage 1: pick term, update window, multiply
  assign x_ext   = WIN_W'(pop_word.sample);
  assign d_ext   = WIN_W'(pop_word.delayed);
  assign wt_base = pop_word.restart ? '0 : wt;
  assign wt_next = wt_base + x_ext - (pop_word.active ? d_ext : '0);

  always_comb begin
    if (!pop_word.active) begin
      src = '0;
    end else if (cfg.effect_mode == MODE_ECHO) begin
      src = d_ext;
    end else begin
      src = wt_base;
    end
  end

  assign prod_c = cfg.decay_gain * src;

  // stage 2: divide by 4096 toward zero, add, saturate
  assign biased = s1_prod + (s1_prod[PROD_W-1] ? BIAS : '0);
  assign term   = biased >>> GAIN_FRAC_BITS;
  assign y      = PROD_W'(s1_x) + term;

  always_ff @(posedge clk) begin
    if (take) begin
      s1_x    <= pop_word.sample;
      s1_prod <= prod_c;
    end
    if (s2_take && s1v) begin
      if (y > Y_MAX) begin
        ow.sample_out <= Y_MAX[SAMPLE_W-1:0];
        ow.clipped    <= 1'b1;
      end else if (y < Y_MIN) begin
        ow.sample_out <= Y_MIN[SAMPLE_W-1:0];
        ow.clipped    <= 1'b1;
      end else begin
        ow.sample_out <= y[SAMPLE_W-1:0];
        ow.clipped    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wt  <= '0;
      s1v <= 1'b0;
      ov  <= 1'b0;
    end else begin
      if (take)      wt  <= wt_next;
      if (pop_ready) s1v <= take;
      if (s2_take)   ov  <= s1v;
    end
  end

  assign out_valid = ov;
  assign out_word  = ow;

endmodule

FILE: sim/tb_echo_and_reverb_effect.sv
// ----------------------------------------------------------------------------
// tb_echo_and_reverb_effect
// Self-checking bench for the echo and reverb effect.
// A built-in predictor tracks the ring, the window sum and the registers, and
// queues one expected word per accepted sample. Every result word is compared
// field by field against the oldest entry. The stimulus covers register access,
// directed corner cases, mid-stream delay changes, the maximum delay, a long
// result-side stall and random streams, with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_echo_and_reverb_effect;
  import eare_pkg::*;

  localparam int CYCLE_LIMIT = 250000;
  localparam int HOLD_CYCLES = 200;
  localparam int RING_DEPTH  = 1 << DELAY_W;
  localparam int MAX_D       = RING_DEPTH - 1;
  localparam int GAIN_ONE    = 1 << GAIN_FRAC_BITS;
  localparam int MAX_REPORTS = 100;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // address slot past the end of the register map
  localparam logic [1:0] REG_SPARE = 2'd3;

  // clock, reset and block ports
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               sample_valid = 1'b0;
  logic               sample_ready;
  in_word_t           sample_word = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  out_word_t          result_word;

  // predictor state: a mirror of the block's registers, ring and window sum
  effect_mode_t              cfg_mode = MODE_ECHO;
  logic [DELAY_W-1:0]        cfg_delay = DELAY_W'(1);
  logic signed [GAIN_W-1:0]  cfg_gain = GAIN_W'(2048);
  logic signed [SAMPLE_W-1:0] past_samples [RING_DEPTH];
  logic [DELAY_W-1:0]        ring_pos = '0;
  logic [DELAY_W:0]          stream_count = '0;
  logic signed [WIN_W-1:0]   window_acc = '0;

  out_word_t pending_outputs [$];

  int mismatch_count = 0;
  int cycle_count = 0;
  bit idle_enable = 1'b1;   // random gaps on both sides
  bit hold_results = 1'b0;  // asks the sink for one long stall

  echo_and_reverb_effect dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_word  (sample_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // ---------------------------------------------------------------------------
  // Mismatch reporting; the log is capped but every mismatch is counted
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: one sample in, one output word out, state updated afterwards.
  // The ring is left unknown; an entry is only used once it has been written
  // since the last restart, so an X here would point at a bad stimulus.
  // ---------------------------------------------------------------------------
  function automatic out_word_t compute_effect(in_word_t w);
    logic signed [SAMPLE_W-1:0] tap;
    logic [DELAY_W-1:0]         rd_pos;
    logic                       active;
    longint                     term;
    longint                     total;
    out_word_t                  r;
    if (w.restart) begin
      stream_count = '0;
      window_acc   = '0;
    end
    active = (stream_count >= cfg_delay);
    rd_pos = ring_pos - cfg_delay;
    if (cfg_delay == 0) begin
      tap = w.sample_in;
    end else begin
      tap = past_samples[rd_pos];
    end

    if (!active) begin
      term = 0;
    end else if (cfg_mode == MODE_ECHO) begin
      term = tap;
    end else begin
      term = window_acc;
    end

    // Q4.12 product, truncated toward zero, then saturated
    total = longint'(w.sample_in) + (longint'(cfg_gain) * term) / GAIN_ONE;
    r.clipped = 1'b0;
    if (total > longint'(SAMPLE_MAX)) begin
      r.sample_out = SAMPLE_MAX;
      r.clipped    = 1'b1;
    end else if (total < longint'(SAMPLE_MIN)) begin
      r.sample_out = SAMPLE_MIN;
      r.clipped    = 1'b1;
    end else begin
      r.sample_out = total[SAMPLE_W-1:0];
    end

    // window sum wraps at its own width
    past_samples[ring_pos] = w.sample_in;
    total = longint'(window_acc) + longint'(w.sample_in) - (active ? longint'(tap) : 0);
    window_acc = total[WIN_W-1:0];
    ring_pos = ring_pos + 1'b1;
    if (stream_count < RING_DEPTH) begin
      stream_count = stream_count + 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, or one long counted stall on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int n;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        result_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_results = 1'b0;
        result_ready <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // each accepted result word against the oldest expectation
  always @(posedge clk) begin : result_check
    out_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected result word", result_word.sample_out, 0);
      end else begin
        want = pending_outputs.pop_front();
        if (result_word.sample_out !== want.sample_out) begin
          report_mismatch("sample_out", result_word.sample_out, want.sample_out);
        end
        if (result_word.clipped !== want.clipped) begin
          report_mismatch("clipped", result_word.clipped, want.clipped);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample side. Called just after a rising edge; returns at the edge that
  // took the word, with valid left high, or after a gap with valid low.
  // ---------------------------------------------------------------------------
  task automatic send_sample(logic signed [SAMPLE_W-1:0] value, logic first);
    in_word_t w;
    w.sample_in = value;
    w.restart   = first;
    sample_valid <= 1'b1;
    sample_word  <= w;
    do @(posedge clk); while (!sample_ready);
    pending_outputs.insert(pending_outputs.size(), compute_effect(w));
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every expected word, plus the pipeline depth
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Register port. Each access ends in the cycle after the bus returns to idle.
  // ---------------------------------------------------------------------------
  task automatic write_register(logic [1:0] idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MODE:  cfg_mode  = value[0] ? MODE_REVERB : MODE_ECHO;
      REG_DELAY: cfg_delay = value[DELAY_W-1:0];
      REG_GAIN:  cfg_gain  = value[GAIN_W-1:0];
      default: ;  // outside the map, no effect
    endcase
  endtask

  task automatic read_register(logic [1:0] idx, output logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read back all three registers against the mirrored settings
  task automatic check_registers();
    logic [PDATA_W-1:0] v;
    read_register(REG_MODE, v);
    if (v[0] !== cfg_mode) report_mismatch("mode register", v[0], cfg_mode);
    read_register(REG_DELAY, v);
    if (v[DELAY_W-1:0] !== cfg_delay) begin
      report_mismatch("delay register", v[DELAY_W-1:0], cfg_delay);
    end
    read_register(REG_GAIN, v);
    if (v[GAIN_W-1:0] !== cfg_gain) begin
      report_mismatch("gain register", $signed(v[GAIN_W-1:0]), cfg_gain);
    end
  endtask

  task automatic configure(effect_mode_t mode, int delay, int gain);
    drain_results();
    write_register(REG_MODE, mode);
    write_register(REG_DELAY, delay);
    write_register(REG_GAIN, gain);
  endtask

  // biased toward the rails and values around zero
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_W'(int'($urandom_range(0, 3)) - 2);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset values, then a short stream on them (echo, one tap back, gain 0.5)
  task automatic test_reset_values();
    check_registers();
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);   // saturates high
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);   // saturates low
    send_sample(0, 1'b0);
    send_sample(1, 1'b0);
  endtask

  // extremes written and read back; a write outside the map changes nothing
  task automatic test_register_access();
    drain_results();
    write_register(REG_MODE, MODE_REVERB);
    write_register(REG_DELAY, MAX_D);
    write_register(REG_GAIN, SAMPLE_MIN);
    check_registers();
    write_register(REG_GAIN, SAMPLE_MAX);
    write_register(REG_DELAY, 0);
    write_register(REG_MODE, MODE_ECHO);
    check_registers();
    write_register(REG_SPARE, '1);
    check_registers();
  endtask

  // zero delay: echo uses the current sample, reverb window stays empty
  task automatic test_zero_delay();
    configure(MODE_ECHO, 0, -32768);
    send_sample(1000, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(-1, 1'b0);
    configure(MODE_REVERB, 0, 32767);
    send_sample(20000, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(5, 1'b0);
  endtask

  // negative products must round toward zero, not down
  task automatic test_truncation();
    configure(MODE_ECHO, 1, 6144);
    send_sample(-3, 1'b1);
    send_sample(-3, 1'b0);
    send_sample(3, 1'b0);
    send_sample(5, 1'b0);
    configure(MODE_ECHO, 1, -1);
    send_sample(4097, 1'b1);
    send_sample(-4097, 1'b0);
    send_sample(0, 1'b0);
  endtask

  // Mid-stream delay changes. Fill the window at the top rail, shrink the
  // delay so the sum is kept while the ring moves to the bottom rail, then
  // widen it again so each word tapping the bottom rail adds a full swing.
  // Last, the maximum delay on a short stream, where no tap is reached yet.
  task automatic test_delay_change();
    int i;
    configure(MODE_REVERB, 40, $urandom_range(0, 65535));
    for (i = 0; i < 50; i++) send_sample(SAMPLE_MAX, i == 0);
    configure(MODE_REVERB, 4, $urandom_range(0, 65535));
    for (i = 0; i < 20; i++) send_sample(SAMPLE_MIN, 1'b0);
    configure(MODE_REVERB, 30, $urandom_range(0, 65535));
    for (i = 0; i < 20; i++) send_sample(SAMPLE_MAX, 1'b0);
    configure(MODE_ECHO, MAX_D, $urandom_range(0, 65535));
    for (i = 0; i < 10; i++) send_sample(rand_sample(), 1'b0);
  endtask

  // long result stall while words keep coming, so the input side backs up;
  // afterwards the sender waits for every word before going on
  task automatic test_backpressure();
    int i;
    configure(MODE_ECHO, 3, 3000);
    hold_results = 1'b1;
    for (i = 0; i < 40; i++) send_sample(rand_sample(), i == 0);
    drain_results();
    for (i = 0; i < 10; i++) send_sample(rand_sample(), 1'b0);
  endtask

  // Streams of random length under random settings. Most start with a
  // restart; the rest carry on from the previous phase, which changes the
  // delay mid-stream. An odd restart inside a stream too.
  task automatic test_random_streams(int n_items);
    int sent;
    int len;
    int delay;
    int gain;
    bit fresh;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 9))
        0:       delay = 0;
        1:       delay = $urandom_range(17, 64);
        2:       delay = MAX_D;
        default: delay = $urandom_range(1, 16);
      endcase
      case ($urandom_range(0, 5))
        0:       gain = -32768;
        1:       gain = 32767;
        2:       gain = $urandom_range(0, 65535);
        default: gain = $urandom_range(0, 8192) - GAIN_ONE;
      endcase
      configure($urandom_range(0, 1) ? MODE_REVERB : MODE_ECHO, delay, gain);
      fresh = ($urandom_range(0, 3) != 0);
      len = $urandom_range(8, 60);
      for (int i = 0; i < len; i++) begin
        send_sample(rand_sample(), (i == 0 && fresh) || $urandom_range(0, 24) == 0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : run
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_values();
    test_register_access();
    test_zero_delay();
    test_truncation();
    test_delay_change();
    test_backpressure();
    test_random_streams(300);

    // closing stretch with no gaps on either side
    idle_enable = 1'b0;
    test_random_streams(60);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
